// ===== rtl/upe_pkg.sv =====
// ----------------------------------------------------------------------------
// upe_pkg: shared types and constants of the URL percent encoder
// Character codes, the queue entry layout and the hex digit helper.
// ----------------------------------------------------------------------------
package upe_pkg;

    localparam int BYTE_W    = 8;
    localparam int BYTES_MAX = 4;
    localparam int IDX_W     = $clog2(BYTES_MAX);

    localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_TWO   = 8'h32;
    localparam logic [BYTE_W-1:0] CH_SIX   = 8'h36;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_A_OFS = 8'h57;  // 'a' minus ten

    // One classified request: the bytes to send, lowest index first.
    typedef struct packed {
        logic [IDX_W-1:0]                  last_idx;
        logic [BYTES_MAX-1:0][BYTE_W-1:0] bytes;
        logic                              str_last;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_entry;

    function automatic logic [BYTE_W-1:0] hex_lower(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + {4'h0, v};
        end
        return CH_A_OFS + {4'h0, v};
    endfunction

endpackage

// ===== rtl/upe_front.sv =====
// ----------------------------------------------------------------------------
// upe_front: request intake and classification
// Tracks a pending backslash and turns each request into a byte list.
// ----------------------------------------------------------------------------
module upe_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic [7:0]              i_s_tdata,
    input  logic                    i_s_tlast,
    output logic                    o_s_tready,
    input  logic                    i_q_full,
    output upe_pkg::t_q_entry       o_push
);
    import upe_pkg::*;

    logic  r_held;
    logic  n_held;
    logic  accept;
    logic  plain;
    logic  gen;
    t_desc enc;
    t_desc desc;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        plain = (i_s_tdata == CH_AMP) || (i_s_tdata == CH_DOT) ||
                ((i_s_tdata >= CH_SLASH) && (i_s_tdata <= CH_TILDE));
        enc          = '0;
        enc.str_last = i_s_tlast;
        if (plain) begin
            enc.bytes[0] = i_s_tdata;
            enc.last_idx = IDX_W'(0);
        end else begin
            enc.bytes[0] = CH_PCT;
            enc.bytes[1] = hex_lower(i_s_tdata[7:4]);
            enc.bytes[2] = hex_lower(i_s_tdata[3:0]);
            enc.last_idx = IDX_W'(2);
        end

        desc          = enc;
        gen           = 1'b1;
        n_held        = 1'b0;
        if (r_held) begin
            if (i_s_tdata == CH_BSL || i_s_tdata == CH_PCT) begin
                desc.bytes[0] = i_s_tdata;
                desc.last_idx = IDX_W'(0);
            end else if (i_s_tdata == CH_AMP) begin
                desc.bytes[0] = CH_PCT;
                desc.bytes[1] = CH_TWO;
                desc.bytes[2] = CH_SIX;
                desc.last_idx = IDX_W'(2);
            end else begin
                // Release the held backslash ahead of the normal encoding.
                desc.bytes[0] = CH_BSL;
                desc.bytes[1] = enc.bytes[0];
                desc.bytes[2] = enc.bytes[1];
                desc.bytes[3] = enc.bytes[2];
                desc.last_idx = enc.last_idx + IDX_W'(1);
            end
        end else if (i_s_tdata == CH_BSL) begin
            desc.bytes[0] = CH_BSL;
            desc.last_idx = IDX_W'(0);
            gen           = i_s_tlast;
            n_held        = !i_s_tlast;
        end
    end

    assign o_push.valid = accept && gen;
    assign o_push.desc  = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

// ===== rtl/upe_fifo.sv =====
// ----------------------------------------------------------------------------
// upe_fifo: request queue between intake and output sequencer
// A small circular buffer of classified byte lists.
// ----------------------------------------------------------------------------
module upe_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  upe_pkg::t_q_entry i_push,
    input  logic              i_pop,
    output logic              o_full,
    output upe_pkg::t_q_entry o_head
);
    import upe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign push        = i_push.valid && !o_full;
    assign pop         = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("push offered while queue full");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count != '0)
        else $error("queue empty after push");

endmodule

// ===== rtl/upe_back.sv =====
// ----------------------------------------------------------------------------
// upe_back: output sequencer
// Walks the byte list at the queue head, one byte per cycle while the receiver is ready, into a register.
// ----------------------------------------------------------------------------
module upe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  upe_pkg::t_q_entry i_head,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,
    output logic [1:0]        o_m_tuser
);
    import upe_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_run_end;
    logic             r_str_end;
    logic             load;
    logic             final_byte;

    assign load       = i_head.valid && (!r_valid || i_m_tready);
    assign final_byte = (r_idx == i_head.desc.last_idx);
    assign o_pop      = load && final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_byte ? '0 : r_idx + IDX_W'(1);
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= i_head.desc.bytes[r_idx];
            r_run_end <= final_byte;
            r_str_end <= final_byte && i_head.desc.str_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tuser  = {r_str_end, r_run_end};

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head.valid |-> r_idx == '0)
        else $error("byte index left over with empty queue");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> r_idx <= i_head.desc.last_idx)
        else $error("byte index beyond request length");
    a_str_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_str_end |-> r_run_end)
        else $error("string end without run end");

endmodule

// ===== rtl/url_percent_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// url_percent_encoder_unit: streaming URL percent encoder
// Encodes name string bytes into URL form, with backslash escape pairs.
// ----------------------------------------------------------------------------
// Usage: name bytes arrive on the slave stream, one per request, with tlast
// on the final byte of the string. Encoded bytes leave on the master stream,
// one per transfer; tuser[0] marks the last byte caused by an input request
// and tuser[1] marks the final encoded byte of the string.
// A request produces one to four output bytes, or none for a backslash held
// while the next byte decides the escape. The output sequencer sends one byte
// per cycle while the receiver is ready; the intake takes a new request every
// cycle while the queue has room. The first byte of a request is written into
// the queue and then into the output register before it appears on the
// master side.
// Reset (synchronous, active low) empties the queue, drops a held backslash
// and clears the output valid flag. When the receiver stalls, the output byte
// holds, the sequencer waits, and the queue fills; once it is full the input
// tready drops until the sequencer frees an entry.
// ----------------------------------------------------------------------------
module url_percent_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // in_last
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser    // [0] run_end, [1] string_end
);
    import upe_pkg::*;

    t_q_entry push;
    t_q_entry head;
    logic     q_full;
    logic     pop;

    // Intake: classifies each byte and keeps the held backslash state.
    upe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tlast  (i_s_axis_tlast),
        .o_s_tready (o_s_axis_tready),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    // Queue of byte lists, so intake and output stall independently.
    upe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // Output sequencer: one encoded byte per cycle, while the receiver is ready, into the output register.
    upe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== dv/url_percent_encoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_encoder_checker: scoreboard for the URL percent encoder
// Watches both streams. Every accepted name byte is encoded here into the
// bytes the block must send, and every sent byte is compared with the oldest
// one still due.
// ----------------------------------------------------------------------------
module url_percent_encoder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // in_last
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [7:0] out_byte
    input  logic [1:0] i_m_axis_tuser,   // [0] run_end, [1] string_end
    output int         o_mismatch_count,
    output int         o_bytes_due
);
    import upe_pkg::*;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam int         PRINT_CAP  = 200;

    typedef struct packed {
        logic [7:0] code;
        logic       run_end;
        logic       string_end;
    } t_encoded;

    t_encoded encoded_due [$];
    t_encoded oldest_due;
    logic     backslash_held = 1'b0;

    initial begin
        o_mismatch_count = 0;
        o_bytes_due      = 0;
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + {4'h0, nib};
        end
        return CH_LOWER_A + {4'h0, nib} - 8'd10;
    endfunction

    // Printing stops after a while so a broken block cannot flood the log,
    // but every mismatch is still counted.
    task automatic report_mismatch(input string what);
        if (o_mismatch_count < PRINT_CAP) begin
            $display("[%0t] encoder mismatch: %s", $time, what);
        end
        o_mismatch_count++;
    endtask

    // Turns one accepted name byte into the bytes it must produce.
    task automatic predict_encoding(input logic [7:0] name_byte, input logic last);
        logic [7:0] seq [4];
        int         n;
        logic       plain;
        t_encoded   e;
        n     = 0;
        plain = 1'b0;
        if (backslash_held) begin
            backslash_held = 1'b0;
            case (name_byte)
                CH_BSL, CH_PCT: begin
                    seq[0] = name_byte;
                    n      = 1;
                end
                CH_AMP: begin
                    seq[0] = CH_PCT;
                    seq[1] = CH_TWO;
                    seq[2] = CH_SIX;
                    n      = 3;
                end
                default: begin
                    // Not an escape pair: the backslash goes out ahead of the byte's normal encoding.
                    seq[0] = CH_BSL;
                    n      = 1;
                    plain  = 1'b1;
                end
            endcase
        end else if (name_byte == CH_BSL) begin
            if (last) begin
                seq[0] = CH_BSL;
                n      = 1;
            end else begin
                backslash_held = 1'b1;
            end
        end else begin
            plain = 1'b1;
        end

        if (plain) begin
            if (name_byte == CH_AMP || name_byte == CH_DOT ||
                (name_byte >= CH_SLASH && name_byte <= CH_TILDE)) begin
                seq[n] = name_byte;
                n      = n + 1;
            end else begin
                seq[n]     = CH_PCT;
                seq[n + 1] = hex_digit(name_byte[7:4]);
                seq[n + 2] = hex_digit(name_byte[3:0]);
                n          = n + 3;
            end
        end

        for (int k = 0; k < n; k++) begin
            e.code       = seq[k];
            e.run_end    = (k == n - 1);
            e.string_end = (k == n - 1) && last;
            encoded_due.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            backslash_held = 1'b0;
            encoded_due.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_encoding(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (encoded_due.size() == 0) begin
                    report_mismatch($sformatf("byte 0x%02h sent with nothing due",
                                              i_m_axis_tdata));
                end else begin
                    oldest_due = encoded_due.pop_front();
                    if (i_m_axis_tdata !== oldest_due.code) begin
                        report_mismatch($sformatf("out_byte 0x%02h, wanted 0x%02h",
                                                  i_m_axis_tdata, oldest_due.code));
                    end
                    if (i_m_axis_tuser[0] !== oldest_due.run_end) begin
                        report_mismatch($sformatf("run_end %b on byte 0x%02h, wanted %b",
                                                  i_m_axis_tuser[0], oldest_due.code,
                                                  oldest_due.run_end));
                    end
                    if (i_m_axis_tuser[1] !== oldest_due.string_end) begin
                        report_mismatch($sformatf("string_end %b on byte 0x%02h, wanted %b",
                                                  i_m_axis_tuser[1], oldest_due.code,
                                                  oldest_due.string_end));
                    end
                end
            end
        end
        o_bytes_due = encoded_due.size();
    end

endmodule

// ===== dv/url_percent_encoder_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_encoder_unit_test: testbench for the URL percent encoder
// Sends a directed set of name strings covering pass-through bytes, encoded
// bytes and every backslash escape pair, then random strings in bursts while
// the receiver stalls in changing patterns. The checker scores the output.
// ----------------------------------------------------------------------------
module url_percent_encoder_unit_test;
    import upe_pkg::*;

    localparam int RANDOM_ITEMS = 280;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 24;
    localparam int OPENING_LEN  = 25;

    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_COIN,     // ready on a coin toss
        RX_PATTERN,  // rotating 16-bit pattern
        RX_CRAWL     // ready with a chance of one in four
    } t_rx_mode;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = 8'h00;
    logic       i_s_axis_tlast  = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;

    int mismatch_count;
    int bytes_due;
    int cycle_count = 0;
    int requests_sent = 0;
    int burst_left = 0;

    t_rx_mode    rx_mode       = RX_OPEN;
    int          rx_phase_left = 0;
    logic [15:0] rx_pattern    = 16'hffff;

    // Opening strings, {in_last, in_byte}: range edges, both sides of the
    // pass-through bands, the zero byte, then every escape pair, a backslash
    // ending a string, and a held backslash followed by a byte needing %xx.
    logic [8:0] opening_requests [OPENING_LEN] = '{
        {1'b0, 8'h00}, {1'b0, 8'h01}, {1'b0, 8'hFF}, {1'b0, CH_AMP},
        {1'b0, CH_DOT}, {1'b0, CH_SLASH}, {1'b0, CH_TILDE}, {1'b0, 8'h7F},
        {1'b0, 8'h2D}, {1'b1, CH_PCT},
        {1'b0, CH_BSL}, {1'b0, CH_BSL},
        {1'b0, CH_BSL}, {1'b0, CH_PCT},
        {1'b0, CH_BSL}, {1'b0, CH_AMP},
        {1'b0, CH_BSL}, {1'b0, 8'h80},
        {1'b1, CH_BSL},
        {1'b0, CH_BSL}, {1'b1, 8'h41},
        {1'b0, CH_BSL}, {1'b1, CH_BSL},
        {1'b0, CH_BSL}, {1'b1, 8'hFF}
    };

    url_percent_encoder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    url_percent_encoder_checker scoreboard (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .i_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_s_axis_tlast   (i_s_axis_tlast),
        .i_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .i_m_axis_tdata   (o_m_axis_tdata),
        .i_m_axis_tuser   (o_m_axis_tuser),
        .o_mismatch_count (mismatch_count),
        .o_bytes_due      (bytes_due)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycle_count, bytes_due);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: switches at random among stall modes, each with a new random pattern.
    always @(negedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = t_rx_mode'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(16, 120);
            rx_pattern    = 16'($urandom);
        end
        rx_phase_left = rx_phase_left - 1;
        rx_pattern    = {rx_pattern[14:0], rx_pattern[15]};
        case (rx_mode)
            RX_OPEN:    i_m_axis_tready <= 1'b1;
            RX_COIN:    i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PATTERN: i_m_axis_tready <= rx_pattern[0];
            default:    i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Mostly name-like bytes with many backslashes and escape partners, plus
    // fully random bytes so every bit of in_byte toggles.
    function automatic logic [7:0] pick_name_byte();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 22) begin
            return CH_BSL;
        end else if (sel < 34) begin
            return ($urandom_range(0, 1) == 0) ? CH_PCT : CH_AMP;
        end else if (sel < 62) begin
            return 8'($urandom_range(CH_SLASH, CH_TILDE));
        end else if (sel < 68) begin
            return CH_DOT;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the request
    // was accepted. Bursts of random length are separated by random gaps.
    task automatic push_request(input logic [7:0] name_byte, input logic last);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        burst_left      = burst_left - 1;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= name_byte;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        requests_sent++;
    endtask

    // Holds the sender off until every predicted byte has been sent.
    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        while (bytes_due != 0) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin
        int  str_len;
        bit  drained_mid_run;
        drained_mid_run = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening_requests[k]) begin
            push_request(opening_requests[k][7:0], opening_requests[k][8]);
        end
        wait_for_drain();

        // Random strings: mostly short, a few long ones.
        while (requests_sent < OPENING_LEN + RANDOM_ITEMS) begin
            str_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 8);
            for (int k = 0; k < str_len; k++) begin
                push_request(pick_name_byte(), k == str_len - 1);
            end
            if (!drained_mid_run && requests_sent >= OPENING_LEN + RANDOM_ITEMS / 2) begin
                wait_for_drain();
                drained_mid_run = 1'b1;
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
